// ===== src/gmt_pkg.sv =====
// Shared types and codes of the group membership table.
`default_nettype none

package gmt_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_FIND   = 3'd1,
    OP_SET    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_READ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef logic [5:0]  eidx_t;
  typedef logic [6:0]  gidx_t;
  typedef logic [5:0]  grp_t;
  typedef logic [31:0] okey_t;
  typedef logic [6:0]  cnt_t;

  typedef struct packed {
    cnt_t    group_total;
    cnt_t    entry_total;
    cnt_t    group_size;
    grp_t    group_out;
    okey_t   key_out;
    eidx_t   index_out;
    status_t status;
  } res_t;

  localparam int OUT_W = 72;

endpackage

`default_nettype wire

// ===== src/gmt_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none

module gmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/gmt_seq.sv =====
// Operation sequencer: read-modify-write of the entry and count RAMs.
`default_nettype none

module gmt_seq #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32,
  localparam int AW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int CW         = $clog2(MAX_ENTRIES + 1),
  localparam int EW         = KEY_BITS + AW
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire gmt_pkg::op_t          op_i,
  input  wire logic [KEY_BITS-1:0]   key_i,
  input  wire gmt_pkg::eidx_t        entry_i,
  input  wire gmt_pkg::gidx_t        group_i,
  output logic                       idle,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output gmt_pkg::res_t              res,
  output logic                       ent_we,
  output logic [AW-1:0]              ent_waddr,
  output logic [EW-1:0]              ent_wdata,
  output logic [AW-1:0]              ent_raddr,
  input  wire logic [EW-1:0]         ent_rd,
  output logic                       cnt_we,
  output logic [AW-1:0]              cnt_waddr,
  output logic [CW-1:0]              cnt_wdata,
  output logic [AW-1:0]              cnt_raddr,
  input  wire logic [CW-1:0]         cnt_rd
);

  localparam int XW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_EXEC  = 16'h0002,
    S_FIND  = 16'h0004,
    S_RD_G  = 16'h0008,
    S_RD_C  = 16'h0010,
    S_SG_OL = 16'h0020,
    S_SG_CO = 16'h0040,
    S_SG_CG = 16'h0080,
    S_RM_L  = 16'h0100,
    S_RM_W  = 16'h0200,
    S_DROP  = 16'h0400,
    S_MOVE  = 16'h0800,
    S_RELAB = 16'h1000,
    S_DONE  = 16'h2000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         efill_r, efill_nxt;
  logic [CW-1:0]         gfill_r, gfill_nxt;
  logic                  pend_r, pend_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  gmt_pkg::op_t          op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  gmt_pkg::eidx_t        e_r, e_nxt;
  gmt_pkg::gidx_t        g_r, g_nxt;
  logic [AW-1:0]         old_r, old_nxt;
  logic [CW-1:0]         cold_r, cold_nxt;
  gmt_pkg::status_t      st_r, st_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [KEY_BITS-1:0]   kout_r, kout_nxt;
  logic [AW-1:0]         gout_r, gout_nxt;
  logic [CW-1:0]         gsz_r, gsz_nxt;

  logic [AW-1:0]         e_a, g_a;
  logic [XW-1:0]         e_x, g_x, efill_x, gfill_x;
  logic [CW-1:0]         last_g;
  logic [KEY_BITS-1:0]   key_rd, key_w;
  logic [AW-1:0]         grp_rd, grp_w;

  assign e_a       = AW'(e_r);
  assign g_a       = AW'(g_r);
  assign e_x       = XW'(e_r);
  assign g_x       = XW'(g_r);
  assign efill_x   = XW'(efill_r);
  assign gfill_x   = XW'(gfill_r);
  assign last_g    = gfill_r - ONE_CNT;
  assign key_rd    = ent_rd[KEY_BITS-1:0];
  assign grp_rd    = ent_rd[KEY_BITS +: AW];
  assign ent_wdata = {grp_w, key_w};

  always_comb begin
    state_nxt = state_r;
    efill_nxt = efill_r;
    gfill_nxt = gfill_r;
    pend_nxt  = pend_r;
    n_nxt     = n_r;
    pidx_nxt  = pidx_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    e_nxt     = e_r;
    g_nxt     = g_r;
    old_nxt   = old_r;
    cold_nxt  = cold_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    kout_nxt  = kout_r;
    gout_nxt  = gout_r;
    gsz_nxt   = gsz_r;
    idle      = 1'b0;
    res_valid = 1'b0;
    ent_we    = 1'b0;
    ent_waddr = e_a;
    key_w     = key_rd;
    grp_w     = g_a;
    ent_raddr = e_a;
    cnt_we    = 1'b0;
    cnt_waddr = old_r;
    cnt_wdata = ONE_CNT;
    cnt_raddr = grp_rd;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          op_nxt    = op_i;
          key_nxt   = key_i;
          e_nxt     = entry_i;
          g_nxt     = group_i;
          st_nxt    = gmt_pkg::ST_OK;
          idx_nxt   = '0;
          kout_nxt  = '0;
          gout_nxt  = '0;
          gsz_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          gmt_pkg::OP_ADD: begin
            if (efill_r >= FULL_CNT || gfill_r >= FULL_CNT) begin
              st_nxt = gmt_pkg::ST_FULL;
            end else begin
              ent_we    = 1'b1;
              ent_waddr = efill_r[AW-1:0];
              key_w     = key_r;
              grp_w     = gfill_r[AW-1:0];
              cnt_we    = 1'b1;
              cnt_waddr = gfill_r[AW-1:0];
              cnt_wdata = ONE_CNT;
              idx_nxt   = efill_r[AW-1:0];
              efill_nxt = efill_r + ONE_CNT;
              gfill_nxt = gfill_r + ONE_CNT;
            end
          end
          gmt_pkg::OP_FIND: begin
            n_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_FIND;
          end
          gmt_pkg::OP_SET: begin
            if (e_x >= efill_x || g_x > gfill_x) begin
              st_nxt = gmt_pkg::ST_RANGE;
            end else begin
              state_nxt = S_SG_OL;
            end
          end
          gmt_pkg::OP_REMOVE: begin
            if (e_x >= efill_x) begin
              st_nxt = gmt_pkg::ST_RANGE;
            end else begin
              efill_nxt = efill_r - ONE_CNT;
              state_nxt = S_RM_L;
            end
          end
          gmt_pkg::OP_CLEAR: begin
            efill_nxt = '0;
            gfill_nxt = '0;
          end
          gmt_pkg::OP_READ: begin
            if (e_x >= efill_x) begin
              st_nxt = gmt_pkg::ST_RANGE;
            end else begin
              state_nxt = S_RD_G;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_FIND: begin
        if (pend_r && key_rd == key_r) begin
          idx_nxt   = pidx_r;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (n_r < efill_r) begin
          ent_raddr = n_r[AW-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = n_r[AW-1:0];
          n_nxt     = n_r + ONE_CNT;
        end else begin
          st_nxt    = gmt_pkg::ST_NOTFOUND;
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_RD_G: begin
        kout_nxt  = key_rd;
        gout_nxt  = grp_rd;
        cnt_raddr = grp_rd;
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        gsz_nxt   = cnt_rd;
        state_nxt = S_DONE;
      end
      S_SG_OL: begin
        old_nxt = grp_rd;
        if (g_x == XW'(grp_rd)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_raddr = grp_rd;
          state_nxt = S_SG_CO;
        end
      end
      S_SG_CO: begin
        cold_nxt = cnt_rd;
        if (g_x == gfill_x) begin
          if (cnt_rd <= ONE_CNT || gfill_r >= FULL_CNT) begin
            state_nxt = S_DONE;
          end else begin
            cnt_we    = 1'b1;
            cnt_waddr = gfill_r[AW-1:0];
            cnt_wdata = ONE_CNT;
            gfill_nxt = gfill_r + ONE_CNT;
            ent_we    = 1'b1;
            state_nxt = S_DROP;
          end
        end else begin
          cnt_raddr = g_a;
          ent_we    = 1'b1;
          state_nxt = S_SG_CG;
        end
      end
      S_SG_CG: begin
        cnt_we    = 1'b1;
        cnt_waddr = g_a;
        cnt_wdata = cnt_rd + ONE_CNT;
        state_nxt = S_DROP;
      end
      S_RM_L: begin
        old_nxt   = grp_rd;
        ent_raddr = efill_r[AW-1:0];
        cnt_raddr = grp_rd;
        state_nxt = S_RM_W;
      end
      S_RM_W: begin
        ent_we    = 1'b1;
        grp_w     = grp_rd;
        cold_nxt  = cnt_rd;
        state_nxt = S_DROP;
      end
      S_DROP: begin
        if (cold_r > ONE_CNT) begin
          cnt_we    = 1'b1;
          cnt_wdata = cold_r - ONE_CNT;
          state_nxt = S_DONE;
        end else begin
          gfill_nxt = last_g;
          cnt_raddr = last_g[AW-1:0];
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_rd;
        n_nxt     = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_RELAB;
      end
      S_RELAB: begin
        if (pend_r && grp_rd == gfill_r[AW-1:0]) begin
          ent_we    = 1'b1;
          ent_waddr = pidx_r;
          grp_w     = old_r;
        end
        if (n_r < efill_r) begin
          ent_raddr = n_r[AW-1:0];
          pend_nxt  = 1'b1;
          pidx_nxt  = n_r[AW-1:0];
          n_nxt     = n_r + ONE_CNT;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      efill_r <= '0;
      gfill_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      efill_r <= efill_nxt;
      gfill_r <= gfill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    pidx_r <= pidx_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    e_r    <= e_nxt;
    g_r    <= g_nxt;
    old_r  <= old_nxt;
    cold_r <= cold_nxt;
    st_r   <= st_nxt;
    idx_r  <= idx_nxt;
    kout_r <= kout_nxt;
    gout_r <= gout_nxt;
    gsz_r  <= gsz_nxt;
  end

  assign res.status      = st_r;
  assign res.index_out   = gmt_pkg::eidx_t'(idx_r);
  assign res.key_out     = gmt_pkg::okey_t'(kout_r);
  assign res.group_out   = gmt_pkg::grp_t'(gout_r);
  assign res.group_size  = gmt_pkg::cnt_t'(gsz_r);
  assign res.entry_total = gmt_pkg::cnt_t'(efill_r);
  assign res.group_total = gmt_pkg::cnt_t'(gfill_r);

  a_groups_le_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (gfill_r <= efill_r))
    else $error("more groups than entries");

  a_entries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    efill_r <= FULL_CNT)
    else $error("entry count beyond capacity");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND || state_r == S_RELAB) |-> (n_r <= efill_r))
    else $error("scan ran past the entry count");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == gmt_pkg::OP_ADD && efill_r < FULL_CNT
     && gfill_r < FULL_CNT)
    |=> (efill_r == $past(efill_r) + ONE_CNT && gfill_r == $past(gfill_r) + ONE_CNT))
    else $error("add did not grow both tables");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == gmt_pkg::OP_CLEAR)
    |=> (efill_r == '0 && gfill_r == '0))
    else $error("clear left entries behind");

endmodule

`default_nettype wire

// ===== src/group_membership_table_unit.sv =====
// Group membership table: top level with RAMs, sequencer and result register.
//
// Input channel in_*: one beat carries one operation (add, find, set group,
// remove, clear, read entry). Result channel out_*: exactly one beat per
// input beat, in order, carrying status, indices, key, group data and the
// entry and group totals after the operation.
// Items are handled one at a time. Find, and a set group or remove that
// empties a group, scan the entry RAM; the other operations do not.
// The scans walk the entry RAM (key and group) through its single read port,
// one entry per cycle, with the read data arriving in the cycle after the address.
// in_tready is high while the sequencer is idle; the next beat is taken while
// a finished result still waits in the output register.
// Reset empties both tables at once; RAM contents stay undefined and are
// only read below the fill counts. When out_tready is low, the result is
// held in the output register and the sequencer waits with the next one.
`default_nettype none

module group_membership_table_unit #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32,
  localparam int IN_W       = ((16 + KEY_BITS + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // op[2:0], key[KEY_BITS-1:0], entry_index[5:0], group_index[6:0], zero pad
  input  wire logic [IN_W-1:0]     in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // status[1:0], index_out[5:0], key_out[31:0], group_out[5:0],
  // group_size[6:0], entry_total[6:0], group_total[6:0], zero pad
  output logic [gmt_pkg::OUT_W-1:0] out_tdata
);

  localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int EW   = KEY_BITS + AW;
  localparam int RES_W = $bits(gmt_pkg::res_t);

  logic                    start;
  logic                    idle;
  logic                    res_valid;
  logic                    res_ready;
  gmt_pkg::res_t           res;
  gmt_pkg::op_t            in_op;
  logic [KEY_BITS-1:0]     in_key;
  gmt_pkg::eidx_t          in_entry;
  gmt_pkg::gidx_t          in_group;

  logic                    ent_we, cnt_we;
  logic [AW-1:0]           ent_waddr, ent_raddr;
  logic [EW-1:0]           ent_wdata, ent_rd;
  logic [AW-1:0]           cnt_waddr, cnt_raddr;
  logic [CW-1:0]           cnt_wdata, cnt_rd;

  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [gmt_pkg::OUT_W-1:0] out_tdata_r;

  assign in_op    = gmt_pkg::op_t'(in_tdata[2:0]);
  assign in_key   = in_tdata[3 +: KEY_BITS];
  assign in_entry = in_tdata[3 + KEY_BITS +: 6];
  assign in_group = in_tdata[9 + KEY_BITS +: 7];

  assign in_tready = idle;
  assign start     = in_tvalid && idle;
  assign res_ready = !out_tvalid_r || out_tready;

  gmt_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_i      (in_op),
    .key_i     (in_key),
    .entry_i   (in_entry),
    .group_i   (in_group),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_raddr (ent_raddr),
    .ent_rd    (ent_rd),
    .cnt_we    (cnt_we),
    .cnt_waddr (cnt_waddr),
    .cnt_wdata (cnt_wdata),
    .cnt_raddr (cnt_raddr),
    .cnt_rd    (cnt_rd)
  );

  gmt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  gmt_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_ENTRIES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {{(gmt_pkg::OUT_W - RES_W){1'b0}}, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

// ===== tb/gmt_checker.sv =====
`timescale 1ns / 100ps
// Reply checker for the group membership table: tracks the tables and compares every reply.
module gmt_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  input  wire logic                      in_tready,
  // op[2:0], key[31:0], entry_index[5:0], group_index[6:0]
  input  wire logic [47:0]               in_tdata,
  input  wire logic                      out_tvalid,
  input  wire logic                      out_tready,
  // status[1:0], index_out[5:0], key_out[31:0], group_out[5:0],
  // group_size[6:0], entry_total[6:0], group_total[6:0], zero pad
  input  wire logic [gmt_pkg::OUT_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending_count
);

  localparam int TABLE_DEPTH = 64;

  typedef struct packed {
    gmt_pkg::gidx_t grp;
    gmt_pkg::eidx_t ent;
    gmt_pkg::okey_t key;
    logic [2:0]     op;
  } op_beat_t;

  gmt_pkg::okey_t key_tab [TABLE_DEPTH];
  gmt_pkg::grp_t  grp_tab [TABLE_DEPTH];
  gmt_pkg::cnt_t  cnt_tab [TABLE_DEPTH];
  int             ent_fill = 0;
  int             grp_fill = 0;
  int             mismatch_total = 0;
  gmt_pkg::res_t  reply_queue [$];
  gmt_pkg::res_t  want;
  gmt_pkg::res_t  got;

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      mismatch_total++;
    end
  endtask

  // drop one member; an emptied group takes the last group and its entries
  task automatic drop_member(input int g);
    if (g < grp_fill) begin
      if (cnt_tab[g] > 0) cnt_tab[g]--;
      if (cnt_tab[g] == 0) begin
        grp_fill--;
        cnt_tab[g] = cnt_tab[grp_fill];
        for (int n = 0; n < ent_fill; n++)
          if (grp_tab[n] == grp_fill) grp_tab[n] = gmt_pkg::grp_t'(g);
      end
    end
  endtask

  task automatic perform_op(input op_beat_t b, output gmt_pkg::res_t r);
    int e;
    int g;
    int old;
    r = '0;
    r.status = gmt_pkg::ST_OK;
    e = b.ent;
    g = b.grp;
    case (b.op)
      gmt_pkg::OP_ADD: begin
        if (ent_fill >= TABLE_DEPTH || grp_fill >= TABLE_DEPTH) begin
          r.status = gmt_pkg::ST_FULL;
        end else begin
          r.index_out = gmt_pkg::eidx_t'(ent_fill);
          key_tab[ent_fill] = b.key;
          grp_tab[ent_fill] = gmt_pkg::grp_t'(grp_fill);
          cnt_tab[grp_fill] = 1;
          ent_fill++;
          grp_fill++;
        end
      end
      gmt_pkg::OP_FIND: begin
        r.status = gmt_pkg::ST_NOTFOUND;
        for (int n = ent_fill - 1; n >= 0; n--)
          if (key_tab[n] == b.key) begin
            r.status = gmt_pkg::ST_OK;
            r.index_out = gmt_pkg::eidx_t'(n);
          end
      end
      gmt_pkg::OP_SET: begin
        if (e >= ent_fill || g > grp_fill) begin
          r.status = gmt_pkg::ST_RANGE;
        end else begin
          old = grp_tab[e];
          if (g != old && (g != grp_fill || (cnt_tab[old] > 1 && grp_fill < TABLE_DEPTH)))
          begin
            if (g == grp_fill) begin
              cnt_tab[g] = 0;
              grp_fill++;
            end
            grp_tab[e] = gmt_pkg::grp_t'(g);
            cnt_tab[g]++;
            drop_member(old);
          end
        end
      end
      gmt_pkg::OP_REMOVE: begin
        if (e >= ent_fill) begin
          r.status = gmt_pkg::ST_RANGE;
        end else begin
          old = grp_tab[e];
          ent_fill--;
          key_tab[e] = key_tab[ent_fill];
          grp_tab[e] = grp_tab[ent_fill];
          drop_member(old);
        end
      end
      gmt_pkg::OP_CLEAR: begin
        ent_fill = 0;
        grp_fill = 0;
      end
      gmt_pkg::OP_READ: begin
        if (e >= ent_fill) begin
          r.status = gmt_pkg::ST_RANGE;
        end else begin
          r.key_out = key_tab[e];
          r.group_out = grp_tab[e];
          r.group_size = cnt_tab[grp_tab[e]];
        end
      end
      default: ;
    endcase
    r.entry_total = gmt_pkg::cnt_t'(ent_fill);
    r.group_total = gmt_pkg::cnt_t'(grp_fill);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ent_fill = 0;
      grp_fill = 0;
      reply_queue.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        perform_op(op_beat_t'(in_tdata), want);
        reply_queue = {reply_queue, want};
      end
      if (out_tvalid && out_tready) begin
        got = gmt_pkg::res_t'(out_tdata[$bits(gmt_pkg::res_t)-1:0]);
        if (reply_queue.size() == 0) begin
          $error("reply beat with no operation outstanding: 0x%0h", got);
          mismatch_total++;
        end else begin
          want = reply_queue.pop_front();
          check_field("status", want.status, got.status);
          check_field("index_out", want.index_out, got.index_out);
          check_field("key_out", want.key_out, got.key_out);
          check_field("group_out", want.group_out, got.group_out);
          check_field("group_size", want.group_size, got.group_size);
          check_field("entry_total", want.entry_total, got.entry_total);
          check_field("group_total", want.group_total, got.group_total);
        end
      end
    end
    fail_count <= mismatch_total;
    pending_count <= reply_queue.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the group membership table: clock, reset, operation stream and verdict.
module tb_top;

  localparam int         TABLE_DEPTH  = 64;
  localparam int         RANDOM_BEATS = 400;
  localparam int         HOLD_PERIOD  = 6000;
  localparam int         HOLD_PHASE   = 700;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [2:0] OP_SPARE_LO  = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY} ready_mode_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [47:0]                in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [gmt_pkg::OUT_W-1:0]  out_tdata;
  int                         fail_count;
  int                         pending_count;

  int                         ent_count = 0;
  int                         burst_left = 0;
  int                         random_sent = 0;
  gmt_pkg::okey_t             key_pool [$];

  ready_mode_t                rdy_mode = RDY_ALWAYS;
  int                         mode_left = 0;
  int                         hold_left = 0;
  int                         cyc_count = 0;

  always #5 clk = ~clk;

  group_membership_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gmt_checker reply_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // result side: stall pattern of its own plus a periodic long hold-off
  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count % HOLD_PERIOD == HOLD_PHASE) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode = ready_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(10, 150);
      end
      mode_left--;
      case (rdy_mode)
        RDY_ALWAYS: out_tready <= 1'b1;
        RDY_COIN:   out_tready <= 1'($urandom_range(0, 1));
        default:    out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_beat(input logic [2:0] op, input gmt_pkg::okey_t key,
                           input gmt_pkg::eidx_t e, input gmt_pkg::gidx_t g);
    in_tdata <= {g, e, key, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    case (op)
      gmt_pkg::OP_ADD: begin
        if (ent_count < TABLE_DEPTH) ent_count++;
        key_pool = {key_pool, key};
        if (key_pool.size() > TABLE_DEPTH) void'(key_pool.pop_front());
      end
      gmt_pkg::OP_REMOVE: if (e < ent_count) ent_count--;
      gmt_pkg::OP_CLEAR:  ent_count = 0;
      default: ;
    endcase
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  function automatic gmt_pkg::eidx_t pick_entry();
    if (ent_count == 0 || $urandom_range(0, 9) == 0)
      return gmt_pkg::eidx_t'($urandom_range(0, 63));
    return gmt_pkg::eidx_t'($urandom_range(0, ent_count - 1));
  endfunction

  function automatic gmt_pkg::gidx_t pick_group();
    if ($urandom_range(0, 9) == 0) return gmt_pkg::gidx_t'($urandom_range(0, 127));
    return gmt_pkg::gidx_t'($urandom_range(0, ent_count + 1));
  endfunction

  function automatic gmt_pkg::okey_t pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return gmt_pkg::okey_t'($urandom);
  endfunction

  // grow the table to full, then knock on it
  task automatic fill_table();
    while (ent_count < TABLE_DEPTH) begin
      case ($urandom_range(0, 9))
        0:       send_beat(gmt_pkg::OP_FIND, pick_key(), pick_entry(), pick_group());
        1:       send_beat(gmt_pkg::OP_READ, pick_key(), pick_entry(), pick_group());
        2:       send_beat(gmt_pkg::OP_SET, pick_key(), pick_entry(), pick_group());
        default: send_beat(gmt_pkg::OP_ADD,
                           $urandom_range(0, 4) == 0 ? pick_key() : gmt_pkg::okey_t'($urandom),
                           pick_entry(), pick_group());
      endcase
      random_sent++;
    end
    repeat (2) begin
      send_beat(gmt_pkg::OP_ADD, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
      random_sent++;
    end
  endtask

  task automatic churn_table(input int beats);
    int pick;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)
        send_beat(gmt_pkg::OP_ADD, pick_key(), pick_entry(), pick_group());
      else if (pick < 35)
        send_beat(gmt_pkg::OP_FIND, pick_key(), pick_entry(), pick_group());
      else if (pick < 60)
        send_beat(gmt_pkg::OP_SET, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
      else if (pick < 75)
        send_beat(gmt_pkg::OP_REMOVE, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
      else if (pick < 94)
        send_beat(gmt_pkg::OP_READ, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
      else if (pick < 96)
        send_beat(gmt_pkg::OP_CLEAR, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
      else
        send_beat(pick[0] ? OP_SPARE_HI : OP_SPARE_LO, gmt_pkg::okey_t'($urandom),
                  gmt_pkg::eidx_t'($urandom_range(0, 63)),
                  gmt_pkg::gidx_t'($urandom_range(0, 127)));
      random_sent++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(gmt_pkg::OP_READ,   32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_REMOVE, 32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_FIND,   32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_ADD,    32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_ADD,    32'hFFFFFFFF, 6'd0,  7'd0);
    send_beat(gmt_pkg::OP_ADD,    32'h12345678, 6'd0,  7'd0);
    send_beat(gmt_pkg::OP_FIND,   32'hFFFFFFFF, 6'd0,  7'd0);
    send_beat(gmt_pkg::OP_FIND,   32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd1,  7'd0);
    send_beat(gmt_pkg::OP_READ,   32'h0,        6'd2,  7'd0);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd2,  7'd2);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd1,  7'd2);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd0,  7'd127);
    send_beat(gmt_pkg::OP_SET,    32'h0,        6'd63, 7'd0);
    send_beat(OP_SPARE_LO,        32'hA5A5A5A5, 6'd63, 7'd127);
    send_beat(OP_SPARE_HI,        32'h5A5A5A5A, 6'd21, 7'd42);
    send_beat(gmt_pkg::OP_REMOVE, 32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_READ,   32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_READ,   32'h0,        6'd1,  7'd0);
    send_beat(gmt_pkg::OP_FIND,   32'h12345678, 6'd0,  7'd0);
    send_beat(gmt_pkg::OP_CLEAR,  32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_READ,   32'h0,        6'd0,  7'd0);
    send_beat(gmt_pkg::OP_FIND,   32'h0,        6'd0,  7'd0);

    fill_table();
    while (random_sent < RANDOM_BEATS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: fill_table();
        3: begin
          send_beat(gmt_pkg::OP_CLEAR, gmt_pkg::okey_t'($urandom), pick_entry(), pick_group());
          random_sent++;
        end
        default: churn_table($urandom_range(20, 60));
      endcase
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
